@@ src/gpw_pkg.sv @@
package gpw_pkg;

    // glyph cell geometry
    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
    localparam int FONT_LISTED = 27;

    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST = 8'd126;

    // scan step counter: 0..GLYPH_BITS-1 are pixels, GLYPH_BITS is the end mark
    localparam int STEP_W = $clog2(GLYPH_BITS + 1);
    localparam logic [STEP_W-1:0] STEP_END = STEP_W'(GLYPH_BITS);
    localparam logic [2:0] COL_LAST = 3'(GLYPH_COLS - 1);

    localparam logic [5:0] PIXEL_BITS_WRITE = 6'd32;

    // register map, byte address 4*index
    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_SCREEN_WIDTH = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PAN_X = 3'd2;
    localparam logic [2:0] REG_PAN_Y = 3'd3;
    localparam logic [2:0] REG_LINE_BYTES = 3'd4;
    localparam logic [2:0] REG_PIXEL_BITS = 3'd5;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [31:0] colour;
    } gpw_in_t;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] pixel_address;
        logic [31:0] pixel_value;
        logic        status;
        logic        last;
    } gpw_out_t;

    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [15:0] pan_x;
        logic [15:0] pan_y;
        logic [17:0] line_bytes;
        logic [5:0]  pixel_bits;
    } gpw_cfg_t;

    // one scan step leaving the scanner
    typedef struct packed {
        logic        bit_set;
        logic        end_mark;
        logic        unsup;
        logic [16:0] x;
        logic [16:0] y;
        logic [31:0] colour;
    } gpw_op_t;

    // one scan step at the end of the address pipeline
    typedef struct packed {
        logic        vis;
        logic        end_mark;
        logic        unsup;
        logic [31:0] prod;
        logic [19:0] xoff;
        logic [31:0] colour;
    } gpw_wr_t;

    // glyphs for codes 32.., row 0 in the top five bits, msb of a row is the left column
    localparam logic [GLYPH_BITS-1:0] FONT_ROM [FONT_LISTED] = '{
        {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        {5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04, 5'h00},
        {5'h0A, 5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00},
        {5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h00, 5'h00},
        {5'h04, 5'h0E, 5'h05, 5'h0E, 5'h14, 5'h0E, 5'h04},
        {5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03},
        {5'h0C, 5'h12, 5'h0C, 5'h12, 5'h11, 5'h0E, 5'h00},
        {5'h04, 5'h04, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02},
        {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08},
        {5'h00, 5'h04, 5'h15, 5'h0E, 5'h15, 5'h04, 5'h00},
        {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00},
        {5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04, 5'h08},
        {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00},
        {5'h00, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00},
        {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        {5'h0E, 5'h11, 5'h01, 5'h0E, 5'h10, 5'h10, 5'h1F},
        {5'h1F, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h11, 5'h0E},
        {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h11, 5'h0E},
        {5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E},
        {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00}
    };

    function automatic logic code_unsupported(input logic [7:0] code);
        return (code < CODE_FIRST) || (code > CODE_LAST);
    endfunction

    // glyph lookup for a supported code; unlisted glyphs are blank
    function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [7:0] code);
        logic [7:0] entry;
        entry = code - CODE_FIRST;
        if (entry < 8'(FONT_LISTED))
            return FONT_ROM[entry[4:0]];
        else
            return '0;
    endfunction

endpackage

@@ src/glyph_pixel_writer_unit.sv @@
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------
// in       | in        | in_valid / in_stall   | gpw_in_t: code, x, y, colour
// out      | out       | out_valid / out_stall | gpw_out_t: one write or marker
// config   | in        | apb psel/penable      | six registers at 4*index
//
// a supported character holds the scanner for one step per glyph bit
// (7 rows of 5) plus one end step; an unsupported code takes only the end step.
// the marker or final write is registered once the end step has passed the three
// address stages and the output register; each earlier write waits in the
// hold-back register until the next drawn bit or the end step catches up.
// rst_n clears all valid bits and loads the register reset values.
// while a result waits under out_stall the pipeline and the scanner hold.
module glyph_pixel_writer_unit
    import gpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  gpw_in_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gpw_out_t           out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    gpw_cfg_t cfg;
    logic     adv;
    logic     op_valid;
    gpw_op_t  op;
    logic     wr_valid;
    gpw_wr_t  wr;

    // configuration registers
    gpw_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // glyph fetch and bit scan
    gpw_scanner u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .adv      (adv),
        .op_valid (op_valid),
        .op       (op)
    );

    // visibility and address pipeline
    gpw_addr_pipe u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .adv      (adv),
        .op_valid (op_valid),
        .op       (op),
        .wr_valid (wr_valid),
        .wr       (wr)
    );

    // last flag, empty markers and output register
    gpw_result_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_valid  (wr_valid),
        .wr        (wr),
        .adv       (adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ src/gpw_cfg_regs.sv @@
module gpw_cfg_regs
    import gpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output gpw_cfg_t           cfg
);

    gpw_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_index = paddr[4:2];
    assign cfg = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width <= 16'd640;
            cfg_reg.screen_height <= 16'd480;
            cfg_reg.pan_x <= 16'd0;
            cfg_reg.pan_y <= 16'd0;
            cfg_reg.line_bytes <= 18'd2560;
            cfg_reg.pixel_bits <= 6'd32;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width <= pwdata[15:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[15:0];
                REG_PAN_X:         cfg_reg.pan_x <= pwdata[15:0];
                REG_PAN_Y:         cfg_reg.pan_y <= pwdata[15:0];
                REG_LINE_BYTES:    cfg_reg.line_bytes <= pwdata[17:0];
                REG_PIXEL_BITS:    cfg_reg.pixel_bits <= pwdata[5:0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_index)
            REG_SCREEN_WIDTH:  prdata = {16'd0, cfg_reg.screen_width};
            REG_SCREEN_HEIGHT: prdata = {16'd0, cfg_reg.screen_height};
            REG_PAN_X:         prdata = {16'd0, cfg_reg.pan_x};
            REG_PAN_Y:         prdata = {16'd0, cfg_reg.pan_y};
            REG_LINE_BYTES:    prdata = {14'd0, cfg_reg.line_bytes};
            REG_PIXEL_BITS:    prdata = {26'd0, cfg_reg.pixel_bits};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ src/gpw_scanner.sv @@
module gpw_scanner
    import gpw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  gpw_in_t in_data,
    input  logic    adv,
    output logic    op_valid,
    output gpw_op_t op
);

    logic                  busy_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [2:0]            col_reg;
    logic [2:0]            row_reg;
    logic [GLYPH_BITS-1:0] glyph_reg;
    logic                  unsup_reg;
    logic [15:0]           pos_x_reg;
    logic [15:0]           pos_y_reg;
    logic [31:0]           colour_reg;

    logic at_end;
    logic free;
    logic accept;
    logic unsup_in;

    assign at_end = (step_reg == STEP_END);
    assign free = !busy_reg || (at_end && adv);
    assign in_stall = !free;
    assign accept = in_valid && free;
    assign unsup_in = code_unsupported(in_data.char_code);

    // current scan step
    assign op_valid = busy_reg;
    assign op.bit_set = glyph_reg[GLYPH_BITS-1] && !at_end;
    assign op.end_mark = at_end;
    assign op.unsup = unsup_reg;
    assign op.x = {1'b0, pos_x_reg} + {14'd0, col_reg};
    assign op.y = {1'b0, pos_y_reg} + {14'd0, row_reg};
    assign op.colour = colour_reg;

    // control: busy flag and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            step_reg <= unsup_in ? STEP_END : '0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (busy_reg && adv)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (col_reg == COL_LAST)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 3'd1;
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                end
            end
        end
    end

    // character payload and glyph shift register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            glyph_reg <= unsup_in ? '0 : font_glyph(in_data.char_code);
            unsup_reg <= unsup_in;
            pos_x_reg <= in_data.pos_x;
            pos_y_reg <= in_data.pos_y;
            colour_reg <= in_data.colour;
        end
        else if (busy_reg && adv)
        begin
            glyph_reg <= {glyph_reg[GLYPH_BITS-2:0], 1'b0};
        end
    end

endmodule

@@ src/gpw_addr_pipe.sv @@
module gpw_addr_pipe
    import gpw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gpw_cfg_t cfg,
    input  logic     adv,
    input  logic     op_valid,
    input  gpw_op_t  op,
    output logic     wr_valid,
    output gpw_wr_t  wr
);

    // stage 1: registered scan step
    logic    s1_valid_reg;
    gpw_op_t s1_reg;

    // stage 2: visibility and panned coordinates
    logic        s2_valid_reg;
    logic        s2_vis_reg;
    logic        s2_end_reg;
    logic        s2_unsup_reg;
    logic [17:0] s2_ax_reg;
    logic [17:0] s2_ay_reg;
    logic [31:0] s2_colour_reg;
    logic        vis_next;

    // stage 3: row product and column offset
    logic        s3_valid_reg;
    gpw_wr_t     s3_reg;
    logic [35:0] row_prod;

    assign vis_next = s1_reg.bit_set
        && (s1_reg.x < {1'b0, cfg.screen_width})
        && (s1_reg.y < {1'b0, cfg.screen_height})
        && (cfg.pixel_bits == PIXEL_BITS_WRITE);

    assign row_prod = {18'd0, s2_ay_reg} * {18'd0, cfg.line_bytes};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= op_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= op;

            s2_vis_reg <= vis_next;
            s2_end_reg <= s1_reg.end_mark;
            s2_unsup_reg <= s1_reg.unsup;
            s2_ax_reg <= {1'b0, s1_reg.x} + {2'b00, cfg.pan_x};
            s2_ay_reg <= {1'b0, s1_reg.y} + {2'b00, cfg.pan_y};
            s2_colour_reg <= s1_reg.colour;

            // four bytes per pixel whenever a write is made
            s3_reg.vis <= s2_vis_reg;
            s3_reg.end_mark <= s2_end_reg;
            s3_reg.unsup <= s2_unsup_reg;
            s3_reg.prod <= row_prod[31:0];
            s3_reg.xoff <= {s2_ax_reg, 2'b00};
            s3_reg.colour <= s2_colour_reg;
        end
    end

    assign wr_valid = s3_valid_reg;
    assign wr = s3_reg;

endmodule

@@ src/gpw_result_merge.sv @@
module gpw_result_merge
    import gpw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    input  gpw_wr_t  wr,
    output logic     adv,
    output logic     out_valid,
    input  logic     out_stall,
    output gpw_out_t out_data
);

    // one write held back until it is known whether it is the final one
    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic [31:0] pend_addr_reg;
    logic [31:0] pend_value_reg;
    logic        pend_load;

    logic        out_valid_reg;
    logic        out_valid_next;
    gpw_out_t    out_reg;
    gpw_out_t    out_next;
    logic [31:0] addr;

    assign adv = !out_valid_reg || !out_stall;
    assign addr = wr.prod + {12'd0, wr.xoff};

    // result selection
    always_comb
    begin
        out_valid_next = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_load = 1'b0;
        out_next = '{write_enable: pend_valid_reg, pixel_address: pend_addr_reg,
                     pixel_value: pend_value_reg, status: 1'b0, last: 1'b0};
        if (wr_valid)
        begin
            if (wr.end_mark)
            begin
                out_valid_next = 1'b1;
                pend_valid_next = 1'b0;
                out_next.last = 1'b1;
                if (wr.unsup || !pend_valid_reg)
                begin
                    out_next.write_enable = 1'b0;
                    out_next.pixel_address = 32'd0;
                    out_next.pixel_value = 32'd0;
                    out_next.status = wr.unsup;
                end
            end
            else if (wr.vis)
            begin
                out_valid_next = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_load = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
            if (pend_load)
            begin
                pend_addr_reg <= addr;
                pend_value_reg <= wr.colour;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule
